### src/iadp_pkg.sv
// Package for the integer ALU with decimal text output.
// Holds the transaction structs, operation kinds, character codes and fixed messages.
// Has no dependencies.
`timescale 1ns / 1ps

package iadp_pkg;

    typedef struct packed {
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic [7:0]         action;
    } in_item_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [2:0] {
        K_ADD  = 3'd0,
        K_SUB  = 3'd1,
        K_MUL  = 3'd2,
        K_DIV  = 3'd3,
        K_MOD  = 3'd4,
        K_DIV0 = 3'd5,
        K_MOD0 = 3'd6,
        K_UNK  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        PM_NUM  = 2'd0,
        PM_DIV0 = 2'd1,
        PM_MOD0 = 2'd2,
        PM_UNK  = 2'd3
    } pmode_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_MOD0 = 2'd2;
    localparam logic [1:0] ST_UNK  = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int MSG_PW   = 5;
    localparam int DIV0_LEN = 23;
    localparam int MOD0_LEN = 21;
    localparam logic [8*DIV0_LEN-1:0] MSG_DIV0 = "Stop : division by zero";
    localparam logic [8*MOD0_LEN-1:0] MSG_MOD0 = "Stop : modulo by zero";

    function automatic logic [7:0] msg_char(input logic mod_sel, input logic [MSG_PW-1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (!mod_sel)
        begin
            if (idx < MSG_PW'(DIV0_LEN))
                c = MSG_DIV0[8*(DIV0_LEN-1-int'(idx)) +: 8];
        end
        else
        begin
            if (idx < MSG_PW'(MOD0_LEN))
                c = MSG_MOD0[8*(MOD0_LEN-1-int'(idx)) +: 8];
        end
        return c;
    endfunction

endpackage

### src/iadp_front.sv
// Front stage: accepts input transactions, sizes the operands and classifies the operator.
// Depends on iadp_pkg.
`timescale 1ns / 1ps

module iadp_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  iadp_pkg::in_item_t    in_data,
    output logic                  cls_valid,
    input  logic                  cls_ready,
    output iadp_pkg::kind_t       cls_kind,
    output logic [DATA_WIDTH-1:0] cls_a,
    output logic [DATA_WIDTH-1:0] cls_b
);
    import iadp_pkg::*;

    logic                  vld_reg;
    logic                  vld_next;
    kind_t                 kind_reg;
    kind_t                 kind_next;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] a_next;
    logic [DATA_WIDTH-1:0] b_next;
    logic                  take;
    logic                  b_zero;

    assign in_ready = !vld_reg || cls_ready;
    assign take     = in_valid && in_ready;

    assign a_next = DATA_WIDTH'(in_data.operand_a);
    assign b_next = DATA_WIDTH'(in_data.operand_b);
    assign b_zero = (b_next == '0);

    always_comb
    begin
        case (in_data.action)
            CH_PLUS:  kind_next = K_ADD;
            CH_MINUS: kind_next = K_SUB;
            CH_STAR:  kind_next = K_MUL;
            CH_SLASH: kind_next = b_zero ? K_DIV0 : K_DIV;
            CH_PCT:   kind_next = b_zero ? K_MOD0 : K_MOD;
            default:  kind_next = K_UNK;
        endcase
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
            vld_next = 1'b1;
        else if (cls_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
        end
    end

    assign cls_valid = vld_reg;
    assign cls_kind  = kind_reg;
    assign cls_a     = a_reg;
    assign cls_b     = b_reg;

endmodule

### src/iadp_queue.sv
// Short queue between the front stage and the execution unit.
// Depends on nothing.
`timescale 1ns / 1ps

module iadp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    wptr_next;
    logic [PW-1:0]    rptr_reg;
    logic [PW-1:0]    rptr_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == PW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        if (pop)
            rptr_next = (rptr_reg == PW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

endmodule

### src/iadp_exec.sv
// Execution unit: add and subtract, shift-add multiply, restoring divide.
// Depends on iadp_pkg.
`timescale 1ns / 1ps

module iadp_exec #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  iadp_pkg::kind_t       cmd_kind,
    input  logic [DATA_WIDTH-1:0] cmd_a,
    input  logic [DATA_WIDTH-1:0] cmd_b,
    output logic                  res_valid,
    input  logic                  res_ready,
    output iadp_pkg::pmode_t      res_mode,
    output logic [DATA_WIDTH-1:0] res_value
);
    import iadp_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [4:0] {
        E_IDLE = 5'b00001,
        E_MUL  = 5'b00010,
        E_DIV  = 5'b00100,
        E_SIGN = 5'b01000,
        E_DONE = 5'b10000
    } estate_t;

    estate_t          state_reg;
    estate_t          state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     acc_next;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     x_next;
    logic [W-1:0]     y_reg;
    logic [W-1:0]     y_next;
    logic             neg_reg;
    logic             neg_next;
    logic             mod_reg;
    logic             mod_next;
    pmode_t           mode_reg;
    pmode_t           mode_next;
    logic             take;
    logic             last_step;
    logic [W-1:0]     mag_a;
    logic [W-1:0]     mag_b;
    logic [W:0]       rem_sh;
    logic [W:0]       diff;
    logic [W-1:0]     pick;

    assign cmd_ready = (state_reg == E_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign last_step = (cnt_reg == CNT_W'(DATA_WIDTH-1));
    assign mag_a     = cmd_a[W-1] ? (W'(0) - cmd_a) : cmd_a;
    assign mag_b     = cmd_b[W-1] ? (W'(0) - cmd_b) : cmd_b;
    assign rem_sh    = {acc_reg, x_reg[W-1]};
    assign diff      = rem_sh - {1'b0, y_reg};
    assign pick      = mod_reg ? acc_reg : x_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        neg_next   = neg_reg;
        mod_next   = mod_reg;
        mode_next  = mode_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (take)
                begin
                    cnt_next  = '0;
                    mode_next = PM_NUM;
                    case (cmd_kind)
                        K_ADD:
                        begin
                            acc_next   = cmd_a + cmd_b;
                            state_next = E_DONE;
                        end
                        K_SUB:
                        begin
                            acc_next   = cmd_a - cmd_b;
                            state_next = E_DONE;
                        end
                        K_MUL:
                        begin
                            acc_next   = '0;
                            x_next     = cmd_a;
                            y_next     = cmd_b;
                            state_next = E_MUL;
                        end
                        K_DIV, K_MOD:
                        begin
                            acc_next   = '0;
                            x_next     = mag_a;
                            y_next     = mag_b;
                            mod_next   = (cmd_kind == K_MOD);
                            neg_next   = (cmd_kind == K_MOD) ? cmd_a[W-1]
                                                             : (cmd_a[W-1] ^ cmd_b[W-1]);
                            state_next = E_DIV;
                        end
                        K_DIV0:
                        begin
                            mode_next  = PM_DIV0;
                            state_next = E_DONE;
                        end
                        K_MOD0:
                        begin
                            mode_next  = PM_MOD0;
                            state_next = E_DONE;
                        end
                        default:
                        begin
                            mode_next  = PM_UNK;
                            state_next = E_DONE;
                        end
                    endcase
                end
            end
            E_MUL:
            begin
                if (y_reg[0])
                    acc_next = acc_reg + x_reg;
                x_next   = {x_reg[W-2:0], 1'b0};
                y_next   = {1'b0, y_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = E_DONE;
            end
            E_DIV:
            begin
                if (!diff[W])
                begin
                    acc_next = diff[W-1:0];
                    x_next   = {x_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[W-1:0];
                    x_next   = {x_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                    state_next = E_SIGN;
            end
            E_SIGN:
            begin
                acc_next   = neg_reg ? (W'(0) - pick) : pick;
                state_next = E_DONE;
            end
            E_DONE:
            begin
                if (res_ready)
                    state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        neg_reg  <= neg_next;
        mod_reg  <= mod_next;
        mode_reg <= mode_next;
    end

    assign res_valid = (state_reg == E_DONE);
    assign res_mode  = mode_reg;
    assign res_value = acc_reg;

endmodule

### src/iadp_print.sv
// Printer: double-dabble conversion to decimal digits, sent as one character per output transaction.
// Depends on iadp_pkg.
`timescale 1ns / 1ps

module iadp_print #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    output logic                  res_ready,
    input  iadp_pkg::pmode_t      res_mode,
    input  logic [DATA_WIDTH-1:0] res_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output iadp_pkg::out_item_t   out_data
);
    import iadp_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int CNT_W  = $clog2(DATA_WIDTH);
    localparam int DIGITS = (DATA_WIDTH * 30103) / 100000 + 1;
    localparam int DIG_IW = $clog2(DIGITS);

    typedef enum logic [7:0] {
        P_IDLE  = 8'b00000001,
        P_CONV  = 8'b00000010,
        P_SKIP  = 8'b00000100,
        P_SIGN  = 8'b00001000,
        P_DIGIT = 8'b00010000,
        P_MSG   = 8'b00100000,
        P_UNK   = 8'b01000000,
        P_NL    = 8'b10000000
    } pstate_t;

    pstate_t           state_reg;
    pstate_t           state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [MSG_PW-1:0] ptr_reg;
    logic [MSG_PW-1:0] ptr_next;
    logic [W-1:0]      bin_reg;
    logic [W-1:0]      bin_next;
    logic [3:0]        digit_reg [DIGITS];
    logic [3:0]        digit_next [DIGITS];
    logic [3:0]        adj [DIGITS];
    logic              neg_reg;
    logic              neg_next;
    logic              mod_reg;
    logic              mod_next;
    logic [1:0]        st_reg;
    logic [1:0]        st_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic              out_free;
    logic              take;
    logic [3:0]        cur_digit;
    logic [MSG_PW-1:0] msg_last;

    assign res_ready = (state_reg == P_IDLE);
    assign take      = res_valid && res_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cur_digit = digit_reg[ptr_reg[DIG_IW-1:0]];
    assign msg_last  = mod_reg ? MSG_PW'(MOD0_LEN - 1) : MSG_PW'(DIV0_LEN - 1);

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
            adj[i] = (digit_reg[i] >= 4'd5) ? (digit_reg[i] + 4'd3) : digit_reg[i];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        bin_next       = bin_reg;
        neg_next       = neg_reg;
        mod_next       = mod_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        for (int i = 0; i < DIGITS; i++)
            digit_next[i] = digit_reg[i];
        case (state_reg)
            P_IDLE:
            begin
                if (take)
                begin
                    cnt_next = '0;
                    ptr_next = '0;
                    case (res_mode)
                        PM_NUM:
                        begin
                            neg_next = res_value[W-1];
                            bin_next = res_value[W-1] ? (W'(0) - res_value) : res_value;
                            for (int i = 0; i < DIGITS; i++)
                                digit_next[i] = 4'd0;
                            st_next    = ST_OK;
                            state_next = P_CONV;
                        end
                        PM_DIV0:
                        begin
                            mod_next   = 1'b0;
                            st_next    = ST_DIV0;
                            state_next = P_MSG;
                        end
                        PM_MOD0:
                        begin
                            mod_next   = 1'b1;
                            st_next    = ST_MOD0;
                            state_next = P_MSG;
                        end
                        default:
                        begin
                            st_next    = ST_UNK;
                            state_next = P_UNK;
                        end
                    endcase
                end
            end
            P_CONV:
            begin
                digit_next[0] = {adj[0][2:0], bin_reg[W-1]};
                for (int i = 1; i < DIGITS; i++)
                    digit_next[i] = {adj[i][2:0], adj[i-1][3]};
                bin_next = {bin_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_WIDTH-1))
                begin
                    ptr_next   = MSG_PW'(DIGITS - 1);
                    state_next = P_SKIP;
                end
            end
            P_SKIP:
            begin
                if (cur_digit == 4'd0 && ptr_reg != '0)
                    ptr_next = ptr_reg - 1'b1;
                else
                    state_next = neg_reg ? P_SIGN : P_DIGIT;
            end
            P_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{text_char: CH_MINUS, last: 1'b0, status: st_reg};
                    state_next     = P_DIGIT;
                end
            end
            P_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{text_char: CH_ZERO + {4'h0, cur_digit},
                                       last: 1'b0, status: st_reg};
                    if (ptr_reg == '0)
                        state_next = P_NL;
                    else
                        ptr_next = ptr_reg - 1'b1;
                end
            end
            P_MSG:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{text_char: msg_char(mod_reg, ptr_reg),
                                       last: 1'b0, status: st_reg};
                    if (ptr_reg == msg_last)
                        state_next = P_NL;
                    else
                        ptr_next = ptr_reg + 1'b1;
                end
            end
            P_UNK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{text_char: CH_ZERO, last: 1'b0, status: st_reg};
                    state_next     = P_NL;
                end
            end
            P_NL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{text_char: CH_NL, last: 1'b1, status: st_reg};
                    state_next     = P_IDLE;
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        neg_reg <= neg_next;
        mod_reg <= mod_next;
        st_reg  <= st_next;
        out_reg <= out_next;
        for (int i = 0; i < DIGITS; i++)
            digit_reg[i] <= digit_next[i];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### src/integer_alu_decimal_printer.sv
// Top level of the integer ALU with decimal text output.
// Instantiates iadp_front, iadp_queue, iadp_exec and iadp_print; depends on iadp_pkg.
//
// Each input transaction carries two signed operands and an ASCII operator and yields a run
// of ASCII characters closed by a newline marked last. The front stage classifies the
// operator and feeds a short queue; the execution unit then computes add and subtract
// directly and runs multiply and divide in its shared shift-add / restoring loop, with a
// sign step after divide and modulo. The printer runs a double-dabble conversion, skips
// leading zeros at one digit a cycle and sends one character a cycle while the output
// accepts it. Since execution of the next transaction overlaps printing, the printer sets
// the sustained rate.
`timescale 1ns / 1ps

module integer_alu_decimal_printer #(
    parameter int DATA_WIDTH  = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  iadp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output iadp_pkg::out_item_t out_data
);
    import iadp_pkg::*;

    localparam int KW = $bits(kind_t);
    localparam int QW = KW + 2 * DATA_WIDTH;

    logic                  cls_valid;
    logic                  cls_ready;
    kind_t                 cls_kind;
    logic [DATA_WIDTH-1:0] cls_a;
    logic [DATA_WIDTH-1:0] cls_b;
    logic [QW-1:0]         q_push_data;
    logic                  q_valid;
    logic                  q_ready;
    logic [QW-1:0]         q_data;
    logic                  res_valid;
    logic                  res_ready;
    pmode_t                res_mode;
    logic [DATA_WIDTH-1:0] res_value;

    assign q_push_data = {cls_kind, cls_a, cls_b};

    iadp_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls_kind  (cls_kind),
        .cls_a     (cls_a),
        .cls_b     (cls_b)
    );

    iadp_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cls_valid),
        .push_ready (cls_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    iadp_exec #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_kind  (kind_t'(q_data[QW-1 -: KW])),
        .cmd_a     (q_data[2*DATA_WIDTH-1 -: DATA_WIDTH]),
        .cmd_b     (q_data[DATA_WIDTH-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_mode  (res_mode),
        .res_value (res_value)
    );

    iadp_print #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_print (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_mode  (res_mode),
        .res_value (res_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### sim/decimal_text_checker.sv
// Checker for the integer ALU with decimal text output: predicts the printed characters.
// Watches both channels, compares every output transaction and counts failures.
// Depends on iadp_pkg.
`timescale 1ns / 1ps

module decimal_text_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  iadp_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  iadp_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  chars_due
);
    import iadp_pkg::*;

    out_item_t expected_text[$];
    out_item_t oldest;

    task automatic push_char(input logic [7:0] ch, input logic [1:0] st, input logic closing);
        out_item_t e;
        e.text_char = ch;
        e.last      = closing;
        e.status    = st;
        expected_text.push_back(e);
    endtask

    task automatic push_message(input string msg, input logic [1:0] st);
        for (int i = 0; i < msg.len(); i++)
            push_char(msg[i], st, 1'b0);
    endtask

    task automatic push_number(input logic [31:0] value);
        logic [31:0] mag;
        logic [7:0]  digits[$];
        if (value[31])
        begin
            push_char(CH_MINUS, ST_OK, 1'b0);
            mag = -value;
        end
        else
        begin
            mag = value;
        end
        do
        begin
            digits.push_front(CH_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
        end
        while (mag != 32'd0);
        foreach (digits[i])
            push_char(digits[i], ST_OK, 1'b0);
    endtask

    task automatic predict_text(input in_item_t item);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        ma;
        logic [31:0]        mb;
        logic [31:0]        quot;
        logic [31:0]        rem;
        logic [1:0]         st;
        a  = item.operand_a;
        b  = item.operand_b;
        st = ST_OK;
        case (item.action)
            CH_PLUS:  push_number(32'(a + b));
            CH_MINUS: push_number(32'(a - b));
            CH_STAR:  push_number(32'(a * b));
            CH_SLASH, CH_PCT:
            begin
                if (b == 32'sd0)
                begin
                    if (item.action == CH_SLASH)
                    begin
                        st = ST_DIV0;
                        push_message("Stop : division by zero", st);
                    end
                    else
                    begin
                        st = ST_MOD0;
                        push_message("Stop : modulo by zero", st);
                    end
                end
                else
                begin
                    ma   = a[31] ? 32'(-a) : 32'(a);
                    mb   = b[31] ? 32'(-b) : 32'(b);
                    quot = ma / mb;
                    rem  = ma % mb;
                    if (item.action == CH_SLASH)
                        push_number((a[31] ^ b[31]) ? -quot : quot);
                    else
                        push_number(a[31] ? -rem : rem);
                end
            end
            default:
            begin
                st = ST_UNK;
                push_char(CH_ZERO, st, 1'b0);
            end
        endcase
        push_char(CH_NL, st, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected character: expected none, got %h", out_data.text_char);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_text.pop_front();
                    if (out_data.text_char !== oldest.text_char)
                    begin
                        $error("text_char: expected %h, got %h",
                               oldest.text_char, out_data.text_char);
                        fail_count++;
                    end
                    if (out_data.last !== oldest.last)
                    begin
                        $error("last: expected %b, got %b", oldest.last, out_data.last);
                        fail_count++;
                    end
                    if (out_data.status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, out_data.status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_text(in_data);
            chars_due = expected_text.size();
        end
    end

endmodule

### sim/testbench.sv
// Top of the regression for the integer ALU with decimal text output.
// Drives operand transactions and output back-pressure, and reports the verdict.
// Depends on iadp_pkg, integer_alu_decimal_printer and decimal_text_checker.
`timescale 1ns / 1ps

module testbench;
    import iadp_pkg::*;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 360;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        chars_due;

    always #1 clk = ~clk;

    integer_alu_decimal_printer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    decimal_text_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .chars_due  (chars_due)
    );

    task automatic offer(input logic signed [31:0] a, input logic signed [31:0] b,
                         input logic [7:0] op, input logic idle_ok);
        int gap;
        if (idle_ok && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_data.operand_a <= a;
        in_data.operand_b <= b;
        in_data.action    <= op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(9))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5, 6:    return $signed(32'($urandom_range(200))) - 32'sd100;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_action();
        if ($urandom_range(99) < 12)
            return 8'($urandom_range(255));
        case ($urandom_range(4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_PCT;
        endcase
    endfunction

    initial
    begin
        int ready_cycle;
        out_ready   = 1'b0;
        ready_cycle = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            ready_cycle++;
            if (ready_cycle >= 2000 && ready_cycle < 2600)
                out_ready <= 1'b0;
            else if (ready_cycle >= 9000 && ready_cycle < 13000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 32);
        end
    end

    initial
    begin
        #2_000_000;
        $display("integer_alu_decimal_printer regression: fail");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        offer(INT_MAX, 32'sd1, CH_PLUS, 1'b1);
        offer(32'sd0, 32'sd0, CH_PLUS, 1'b1);
        offer(INT_MIN, INT_MIN, CH_PLUS, 1'b1);
        offer(INT_MIN, 32'sd1, CH_MINUS, 1'b1);
        offer(-32'sd1, INT_MAX, CH_MINUS, 1'b1);
        offer(32'sd5, 32'sd5, CH_MINUS, 1'b1);
        offer(INT_MAX, INT_MAX, CH_STAR, 1'b1);
        offer(-32'sd12345, 32'sd6789, CH_STAR, 1'b1);
        offer(INT_MIN, 32'sd0, CH_STAR, 1'b1);
        offer(32'sd1000000000, 32'sd7, CH_SLASH, 1'b1);
        offer(32'sd7, -32'sd2, CH_SLASH, 1'b1);
        offer(INT_MIN, -32'sd1, CH_SLASH, 1'b1);
        offer(INT_MIN, 32'sd1, CH_SLASH, 1'b1);
        offer(32'sd0, 32'sd5, CH_SLASH, 1'b1);
        offer(32'sd42, 32'sd0, CH_SLASH, 1'b1);
        offer(-32'sd7, 32'sd2, CH_PCT, 1'b1);
        offer(32'sd7, -32'sd2, CH_PCT, 1'b1);
        offer(INT_MIN, -32'sd1, CH_PCT, 1'b1);
        offer(INT_MAX, INT_MIN, CH_PCT, 1'b1);
        offer(-32'sd3, 32'sd0, CH_PCT, 1'b1);
        offer(32'sd9, 32'sd9, 8'h00, 1'b1);
        offer(-32'sd9, 32'sd9, 8'hFF, 1'b1);
        offer(32'sd1, 32'sd2, 8'h3D, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            offer(pick_operand(), pick_operand(), pick_action(), !(i >= 160 && i < 220));
        in_valid <= 1'b0;

        wait (chars_due == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && chars_due == 0)
            $display("integer_alu_decimal_printer regression: pass");
        else
            $display("integer_alu_decimal_printer regression: fail");
        $finish;
    end

endmodule
